// ===== sv/wpc_pkg.sv =====
// shared types and constants for the way-predicted set-associative cache
// used by wpc_way_sel and way_predicted_set_assoc_cache_core
package wpc_pkg;

  localparam int unsigned WAYS   = 4;
  localparam int unsigned LRU_W  = 16;
  localparam int unsigned PRED_W = 2;

  localparam logic [15:0] LRU_ROW = 16'hF000;
  localparam logic [15:0] LRU_COL = 16'h8888;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_REQ    = 2'd1;
  localparam logic [1:0] KIND_WT     = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] CLS_PRED  = 2'd0;
  localparam logic [1:0] CLS_OTHER = 2'd1;
  localparam logic [1:0] CLS_FILL  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RDATA,
    ST_SEND,
    ST_CAPT
  } state_e;

  typedef struct packed {
    logic       hit;
    logic [1:0] way;
    logic       other;
    logic [1:0] victim;
  } sel_t;

endpackage

// ===== sv/way_predicted_set_assoc_cache_core.sv =====
// top level of the way-predicted 4-way write-through cache
// depends on wpc_pkg, wpc_ram and wpc_way_sel
//
// usage: words enter on the s_axis channel (tuser = command: read, write or
// refill beat) and results leave on the m_axis channel (tuser = result kind).
// tlast marks the final result word caused by one input word.
// a read hit passes the LOOKUP and RDATA states before its data word is
// registered for output; a write hit streams LINE_BYTES write-through words,
// each read from the single data ram port in SEND, which waits while the
// output register is full, and registered in CAPT. a miss gives one refill
// request word; LINE_BYTES refill beats are then written straight into the
// data ram and the access is replayed after the last one. an access during a
// pending refill gets one reject word. after reset a clearing pass zeroes the
// tag/lru/prediction ram, one set per cycle; s_axis_tready stays low meanwhile.
// one word is taken at a time; tready is low while a word is in work or
// while the output register holds a word the receiver has not taken.
module way_predicted_set_assoc_cache_core #(
  parameter int unsigned SET_COUNT  = 64,
  parameter int unsigned LINE_BYTES = 16,
  parameter int unsigned ADDR_BITS  = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // address, data_byte
  input  logic [((ADDR_BITS+8+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic [1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // result_byte, line_address, hit_class, hit_way
  output logic [((ADDR_BITS+12+7)/8)*8-1:0] m_axis_tdata_o,
  // kind
  output logic [1:0] m_axis_tuser_o,
  // last_of_run
  output logic m_axis_tlast_o
);

  localparam int unsigned SETW  = $clog2(SET_COUNT);
  localparam int unsigned OFFW  = $clog2(LINE_BYTES);
  localparam int unsigned TAGW  = ADDR_BITS - SETW - OFFW;
  localparam int unsigned MW    = 4 + 4*TAGW + 16 + 2;
  localparam int unsigned DW    = SETW + 2 + OFFW;
  localparam int unsigned OUT_W = ((ADDR_BITS+12+7)/8)*8;
  localparam int unsigned TAG_LO = 18;
  localparam int unsigned VAL_LO = 18 + 4*TAGW;

  wpc_pkg::state_e state_q, state_d;

  // control
  logic [SETW-1:0] clr_q, clr_d;
  logic pend_q, pend_d;
  logic [OFFW-1:0] beat_q, beat_d;
  logic [OFFW-1:0] idx_q, idx_d;
  logic replay_q, replay_d;
  logic out_valid_q, out_valid_d;

  // payload
  logic [ADDR_BITS-1:0] pend_addr_q, pend_addr_d;
  logic pend_wr_q, pend_wr_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic [1:0] pend_way_q, pend_way_d;
  logic [ADDR_BITS-1:0] cur_addr_q, cur_addr_d;
  logic cur_wr_q, cur_wr_d;
  logic [7:0] cur_byte_q, cur_byte_d;
  logic [1:0] srv_way_q, srv_way_d;
  logic [1:0] srv_cls_q, srv_cls_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [ADDR_BITS-1:0] out_line_q, out_line_d;
  logic [1:0] out_cls_q, out_cls_d;
  logic [1:0] out_way_q, out_way_d;
  logic out_last_q, out_last_d;

  logic [ADDR_BITS-1:0] in_addr;
  logic [7:0] in_byte;
  logic in_acc, out_free;

  logic meta_we;
  logic [SETW-1:0] meta_addr;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic data_we;
  logic [DW-1:0] data_addr;
  logic [7:0] data_wdata, data_rdata;

  logic [3:0] valid_v, match_v;
  logic [TAGW-1:0] cur_tag;
  logic [SETW-1:0] cur_set;
  wpc_pkg::sel_t sel;

  assign in_addr  = s_axis_tdata_i[ADDR_BITS-1:0];
  assign in_byte  = s_axis_tdata_i[ADDR_BITS +: 8];
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == wpc_pkg::ST_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  assign cur_tag = cur_addr_q[ADDR_BITS-1 -: TAGW];
  assign cur_set = cur_addr_q[OFFW +: SETW];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      valid_v[w] = meta_rdata[VAL_LO + w];
      match_v[w] = valid_v[w] && (meta_rdata[TAG_LO + w*TAGW +: TAGW] == cur_tag);
    end
  end

  wpc_way_sel u_sel (
    .valid_i (valid_v),
    .match_i (match_v),
    .pred_i  (meta_rdata[1:0]),
    .lru_i   (meta_rdata[17:2]),
    .sel_o   (sel)
  );

  wpc_ram #(.WIDTH(MW), .DEPTH(SET_COUNT)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .addr_i  (meta_addr),
    .wdata_i (meta_wdata),
    .rdata_o (meta_rdata)
  );

  wpc_ram #(.WIDTH(8), .DEPTH(SET_COUNT*4*LINE_BYTES)) u_data (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .addr_i  (data_addr),
    .wdata_i (data_wdata),
    .rdata_o (data_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpc_pkg::ST_CLEAR: begin
        if (clr_q == SETW'(SET_COUNT-1)) state_d = wpc_pkg::ST_IDLE;
      end
      wpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((s_axis_tuser_i == wpc_pkg::CMD_READ || s_axis_tuser_i == wpc_pkg::CMD_WRITE)
              && !pend_q) begin
            state_d = wpc_pkg::ST_LOOKUP;
          end else if (s_axis_tuser_i == wpc_pkg::CMD_FILL && pend_q && (&beat_q)) begin
            state_d = wpc_pkg::ST_LOOKUP;
          end
        end
      end
      wpc_pkg::ST_LOOKUP: begin
        if (!replay_q && !sel.hit) state_d = wpc_pkg::ST_IDLE;
        else if (cur_wr_q) state_d = wpc_pkg::ST_SEND;
        else state_d = wpc_pkg::ST_RDATA;
      end
      wpc_pkg::ST_RDATA: state_d = wpc_pkg::ST_IDLE;
      wpc_pkg::ST_SEND: begin
        if (out_free) state_d = wpc_pkg::ST_CAPT;
      end
      wpc_pkg::ST_CAPT: begin
        state_d = (&idx_q) ? wpc_pkg::ST_IDLE : wpc_pkg::ST_SEND;
      end
      default: state_d = wpc_pkg::ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [1:0] way;
    logic [15:0] lru;
    logic load;
    way = replay_q ? pend_way_q : sel.way;
    lru = (meta_rdata[17:2] | (wpc_pkg::LRU_ROW >> {way, 2'b00}))
          & ~(wpc_pkg::LRU_COL >> way);
    load = 1'b0;
    clr_d = clr_q;  pend_d = pend_q;  beat_d = beat_q;  idx_d = idx_q;
    replay_d = replay_q;
    pend_addr_d = pend_addr_q;  pend_wr_d = pend_wr_q;
    pend_byte_d = pend_byte_q;  pend_way_d = pend_way_q;
    cur_addr_d = cur_addr_q;  cur_wr_d = cur_wr_q;  cur_byte_d = cur_byte_q;
    srv_way_d = srv_way_q;  srv_cls_d = srv_cls_q;
    out_kind_d = out_kind_q;  out_byte_d = out_byte_q;  out_line_d = out_line_q;
    out_cls_d = out_cls_q;  out_way_d = out_way_q;  out_last_d = out_last_q;
    meta_we = 1'b0;  meta_addr = cur_set;  meta_wdata = meta_rdata;
    data_we = 1'b0;  data_addr = {cur_set, srv_way_q, idx_q};  data_wdata = cur_byte_q;
    unique case (state_q)
      wpc_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_addr  = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + 1'b1;
      end
      wpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == wpc_pkg::CMD_READ || s_axis_tuser_i == wpc_pkg::CMD_WRITE) begin
            if (pend_q) begin
              load = 1'b1;
              out_kind_d = wpc_pkg::KIND_REJECT;  out_byte_d = '0;
              out_line_d = {in_addr[ADDR_BITS-1:OFFW], OFFW'(0)};
              out_cls_d = '0;  out_way_d = '0;  out_last_d = 1'b1;
            end else begin
              meta_addr  = in_addr[OFFW +: SETW];
              cur_addr_d = in_addr;
              cur_wr_d   = (s_axis_tuser_i == wpc_pkg::CMD_WRITE);
              cur_byte_d = in_byte;
              replay_d   = 1'b0;
            end
          end else if (s_axis_tuser_i == wpc_pkg::CMD_FILL && pend_q) begin
            // refill beats go straight to the victim line chosen at the miss
            data_we    = 1'b1;
            data_addr  = {pend_addr_q[OFFW +: SETW], pend_way_q, beat_q};
            data_wdata = in_byte;
            beat_d     = beat_q + 1'b1;
            if (&beat_q) begin
              pend_d     = 1'b0;
              meta_addr  = pend_addr_q[OFFW +: SETW];
              cur_addr_d = pend_addr_q;
              cur_wr_d   = pend_wr_q;
              cur_byte_d = pend_byte_q;
              replay_d   = 1'b1;
            end
          end
        end
      end
      wpc_pkg::ST_LOOKUP: begin
        if (replay_q || sel.hit) begin
          meta_we = 1'b1;
          meta_wdata[17:2] = lru;
          if (replay_q) begin
            meta_wdata[1:0] = way;
            meta_wdata[VAL_LO + way] = 1'b1;
            meta_wdata[TAG_LO + way*TAGW +: TAGW] = cur_tag;
          end
          srv_way_d = way;
          srv_cls_d = replay_q ? wpc_pkg::CLS_FILL
                    : (sel.other ? wpc_pkg::CLS_OTHER : wpc_pkg::CLS_PRED);
          data_addr = {cur_set, way, cur_addr_q[OFFW-1:0]};
          data_we   = cur_wr_q;
          idx_d     = '0;
        end else begin
          pend_d      = 1'b1;
          pend_addr_d = cur_addr_q;
          pend_wr_d   = cur_wr_q;
          pend_byte_d = cur_byte_q;
          pend_way_d  = sel.victim;
          beat_d      = '0;
          load = 1'b1;
          out_kind_d = wpc_pkg::KIND_REQ;  out_byte_d = '0;
          out_line_d = {cur_addr_q[ADDR_BITS-1:OFFW], OFFW'(0)};
          out_cls_d = '0;  out_way_d = '0;  out_last_d = 1'b1;
        end
      end
      wpc_pkg::ST_RDATA: begin
        load = 1'b1;
        out_kind_d = wpc_pkg::KIND_DATA;  out_byte_d = data_rdata;
        out_line_d = {cur_addr_q[ADDR_BITS-1:OFFW], OFFW'(0)};
        out_cls_d = srv_cls_q;  out_way_d = srv_way_q;  out_last_d = 1'b1;
      end
      wpc_pkg::ST_SEND: begin
        data_addr = {cur_set, srv_way_q, idx_q};
      end
      wpc_pkg::ST_CAPT: begin
        load = 1'b1;
        out_kind_d = wpc_pkg::KIND_WT;  out_byte_d = data_rdata;
        out_line_d = {cur_addr_q[ADDR_BITS-1:OFFW], OFFW'(0)};
        out_cls_d = srv_cls_q;  out_way_d = srv_way_q;  out_last_d = &idx_q;
        idx_d = idx_q + 1'b1;
      end
      default: ;
    endcase
    out_valid_d = load || (out_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpc_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      beat_q      <= '0;
      idx_q       <= '0;
      replay_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      beat_q      <= beat_d;
      idx_q       <= idx_d;
      replay_q    <= replay_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_wr_q   <= pend_wr_d;
    pend_byte_q <= pend_byte_d;
    pend_way_q  <= pend_way_d;
    cur_addr_q  <= cur_addr_d;
    cur_wr_q    <= cur_wr_d;
    cur_byte_q  <= cur_byte_d;
    srv_way_q   <= srv_way_d;
    srv_cls_q   <= srv_cls_d;
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_line_q  <= out_line_d;
    out_cls_q   <= out_cls_d;
    out_way_q   <= out_way_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_W'({out_way_q, out_cls_q, out_line_q, out_byte_q});

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wpc_pkg::ST_CLEAR |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");

  a_req_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == wpc_pkg::KIND_REQ |-> m_axis_tlast_o)
    else $error("refill request not marked last");

  a_reject_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pend_q && (s_axis_tuser_i == wpc_pkg::CMD_READ ||
    s_axis_tuser_i == wpc_pkg::CMD_WRITE)
    |=> m_axis_tvalid_o && m_axis_tuser_o == wpc_pkg::KIND_REJECT)
    else $error("access during refill not rejected");

  a_fill_ends_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> $past(in_acc && s_axis_tuser_i == wpc_pkg::CMD_FILL))
    else $error("refill ended without a refill beat");

endmodule

// ===== sv/wpc_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module wpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/wpc_way_sel.sv =====
// hit search in predicted-way order and victim choice for one set
// depends on wpc_pkg
module wpc_way_sel (
  input  logic [3:0]   valid_i,
  input  logic [3:0]   match_i,
  input  logic [1:0]   pred_i,
  input  logic [15:0]  lru_i,
  output wpc_pkg::sel_t sel_o
);

  always_comb begin
    logic [1:0] w;
    logic       found;
    logic       vfound;
    sel_o  = '0;
    found  = 1'b0;
    vfound = 1'b0;
    // predicted way first, then pred+1..pred+3
    for (int i = 0; i < 4; i++) begin
      w = pred_i + 2'(i);
      if (!found && match_i[w]) begin
        found       = 1'b1;
        sel_o.hit   = 1'b1;
        sel_o.way   = w;
        sel_o.other = (i != 0);
      end
    end
    sel_o.victim = 2'd3;
    for (int i = 0; i < 4; i++) begin
      if (!vfound && !valid_i[i]) begin
        vfound       = 1'b1;
        sel_o.victim = 2'(i);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (!vfound && lru_i[15-4*i -: 4] == 4'd0) begin
        vfound       = 1'b1;
        sel_o.victim = 2'(i);
      end
    end
  end

endmodule

// ===== dv/way_predicted_set_assoc_cache_checker.sv =====
// checker for way_predicted_set_assoc_cache_core: watches both stream channels,
// predicts the result words of every accepted input word and compares them
// depends on wpc_pkg for the command, kind and hit class codes and the lru masks
module way_predicted_set_assoc_cache_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          errors_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [24:0] line;
    logic [1:0]  cls;
    logic [1:0]  way;
    logic        last;
  } cache_word_t;

  // cache image
  logic [14:0] tag_q   [64][4];
  logic        vld_q   [64][4];
  logic [15:0] lru_q   [64];
  logic [1:0]  pred_q  [64];
  logic [7:0]  bytes_q [64][4][16];
  logic        fill_busy;
  logic [24:0] miss_addr;
  logic        miss_wr;
  logic [7:0]  miss_byte;
  logic [7:0]  refill_q [16];
  int          beats;

  cache_word_t expected_words[$];

  function automatic logic [24:0] line_of(logic [24:0] a);
    return {a[24:4], 4'd0};
  endfunction

  task automatic push_word(logic [1:0] kind, logic [7:0] data, logic [24:0] a,
                           logic [1:0] cls, logic [1:0] way, logic last);
    cache_word_t w;
    w.kind = kind; w.data = data; w.line = line_of(a);
    w.cls = cls; w.way = way; w.last = last;
    expected_words.push_back(w);
  endtask

  // hit or replay after refill: lru update, then data word or write-through line
  task automatic serve_access(int set, int way, logic [1:0] cls, logic wr,
                              logic [24:0] a, logic [7:0] b);
    logic [15:0] row;
    logic [15:0] col;
    row = wpc_pkg::LRU_ROW >> (4 * way);
    col = wpc_pkg::LRU_COL >> way;
    lru_q[set] = (lru_q[set] | row) & ~col;
    if (!wr) begin
      push_word(wpc_pkg::KIND_DATA, bytes_q[set][way][a[3:0]], a, cls, way[1:0], 1'b1);
    end else begin
      bytes_q[set][way][a[3:0]] = b;
      for (int j = 0; j < 16; j++)
        push_word(wpc_pkg::KIND_WT, bytes_q[set][way][j], a, cls, way[1:0], j == 15);
    end
  endtask

  task automatic predict_word(logic [1:0] cmd, logic [24:0] a, logic [7:0] b);
    int set;
    int way;
    int victim;
    if (cmd == wpc_pkg::CMD_READ || cmd == wpc_pkg::CMD_WRITE) begin
      if (fill_busy) begin
        push_word(wpc_pkg::KIND_REJECT, 8'd0, a, wpc_pkg::CLS_PRED, 2'd0, 1'b1);
        return;
      end
      set = a[9:4];
      for (int i = 0; i < 4; i++) begin
        way = (pred_q[set] + i) % 4;
        if (vld_q[set][way] && tag_q[set][way] == a[24:10]) begin
          serve_access(set, way, i == 0 ? wpc_pkg::CLS_PRED : wpc_pkg::CLS_OTHER,
                       cmd == wpc_pkg::CMD_WRITE, a, b);
          return;
        end
      end
      fill_busy = 1'b1;
      miss_addr = a;
      miss_wr = (cmd == wpc_pkg::CMD_WRITE);
      miss_byte = b;
      beats = 0;
      push_word(wpc_pkg::KIND_REQ, 8'd0, a, wpc_pkg::CLS_PRED, 2'd0, 1'b1);
    end else if (cmd == wpc_pkg::CMD_FILL && fill_busy) begin
      refill_q[beats] = b;
      beats++;
      if (beats < 16) return;
      beats = 0;
      fill_busy = 1'b0;
      set = miss_addr[9:4];
      victim = -1;
      for (int w = 0; w < 4; w++)
        if (victim < 0 && !vld_q[set][w]) victim = w;
      for (int w = 0; w < 3; w++)
        if (victim < 0 && lru_q[set][15-4*w -: 4] == 4'd0) victim = w;
      if (victim < 0) victim = 3;
      vld_q[set][victim] = 1'b1;
      tag_q[set][victim] = miss_addr[24:10];
      for (int j = 0; j < 16; j++) bytes_q[set][victim][j] = refill_q[j];
      pred_q[set] = victim[1:0];
      serve_access(set, victim, wpc_pkg::CLS_FILL, miss_wr, miss_addr, miss_byte);
    end
  endtask

  task automatic compare_word();
    cache_word_t got;
    cache_word_t exp_w;
    got.kind = m_tuser_i;
    got.data = m_tdata_i[7:0];
    got.line = m_tdata_i[32:8];
    got.cls  = m_tdata_i[34:33];
    got.way  = m_tdata_i[36:35];
    got.last = m_tlast_i;
    if (expected_words.size() == 0) begin
      errors_o++;
      $display("%0t: unexpected result word: actual %p", $realtime, got);
      return;
    end
    exp_w = expected_words.pop_front();
    if (got !== exp_w) begin
      errors_o++;
      $display("%0t: result word mismatch: expected %p actual %p", $realtime, exp_w, got);
    end
  endtask

  initial begin
    errors_o = 0;
    outstanding_o = 0;
    for (int s = 0; s < 64; s++) begin
      lru_q[s] = '0;
      pred_q[s] = '0;
      for (int w = 0; w < 4; w++) begin
        tag_q[s][w] = '0;
        vld_q[s][w] = 1'b0;
        for (int j = 0; j < 16; j++) bytes_q[s][w][j] = '0;
      end
    end
    fill_busy = 1'b0;
    miss_addr = '0;
    miss_wr = 1'b0;
    miss_byte = '0;
    beats = 0;
  end

  // output first: a word accepted on the same edge cannot cause this result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) compare_word();
      if (s_tvalid_i && s_tready_i) predict_word(s_tuser_i, s_tdata_i[24:0], s_tdata_i[32:25]);
      outstanding_o = expected_words.size();
    end
  end

endmodule

// ===== dv/way_predicted_set_assoc_cache_core_test.sv =====
// top of the cache core testbench: clock, reset, stimulus and final verdict
// depends on wpc_pkg, way_predicted_set_assoc_cache_core and the checker
module way_predicted_set_assoc_cache_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // command code the block ignores
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          errors;
  int          outstanding;

  int          runs_sent;
  int          runs_done;
  logic [1:0]  last_kind;
  int          req_seen;
  int          items;
  int          idle_cycles;
  bit          hold_req;
  bit          hold_done;
  bit          tx_steady;
  bit          rx_steady;
  logic [14:0] tag_pool[6];
  logic [5:0]  set_pool[4];

  way_predicted_set_assoc_cache_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  way_predicted_set_assoc_cache_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // completed runs and refill requests seen on the result side
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready && m_tlast) begin
      runs_done <= runs_done + 1;
      last_kind <= m_tuser;
      if (m_tuser == wpc_pkg::KIND_REQ) req_seen <= req_seen + 1;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, steady stretches and one long hold-off
  initial begin
    int w;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_steady = ~rx_steady;
      w = rx_steady ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [24:0] a, logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, b, a};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    if (cmd != CMD_NONE) items++;
  endtask

  task automatic wait_runs();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (runs_done == runs_sent);
    @(negedge clk_i);
  endtask

  // one access; on a miss maybe a rejected access and an unused command word, then the 16 refill beats
  task automatic access(logic [1:0] cmd, logic [24:0] a, logic [7:0] b, bit edge_bytes);
    send_word(cmd, a, b);
    runs_sent++;
    wait_runs();
    if (last_kind == wpc_pkg::KIND_REQ) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 1)), 25'($urandom), 8'($urandom));
        runs_sent++;
      end
      if ($urandom_range(0, 19) == 0) send_word(CMD_NONE, 25'($urandom), 8'($urandom));
      for (int j = 0; j < 16; j++)
        send_word(wpc_pkg::CMD_FILL, 25'($urandom),
                  edge_bytes ? ((j % 2) ? 8'hFF : 8'h00) : 8'($urandom));
      runs_sent++;
      wait_runs();
    end
  endtask

  function automatic logic [24:0] pool_addr();
    return {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)],
            4'($urandom_range(0, 15))};
  endfunction

  initial begin
    int burst_req;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = wpc_pkg::CMD_READ;
    rst_ni = 1'b0;
    runs_sent = 0;
    runs_done = 0;
    last_kind = wpc_pkg::KIND_DATA;
    req_seen = 0;
    items = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    tag_pool = '{15'h0000, 15'h7FFF, 15'h5555, 15'h2AAA, 15'($urandom), 15'($urandom)};
    set_pool = '{6'd0, 6'd63, 6'd21, 6'($urandom)};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, stray beats, unused command
    access(wpc_pkg::CMD_READ, 25'd0, 8'h00, 1'b1);
    access(wpc_pkg::CMD_READ, 25'd15, 8'hFF, 1'b0);
    send_word(wpc_pkg::CMD_FILL, 25'h1FFFFFF, 8'hFF);
    send_word(CMD_NONE, 25'h1FFFFFF, 8'hFF);
    access(wpc_pkg::CMD_WRITE, 25'h1FFFFFF, 8'hFF, 1'b1);
    access(wpc_pkg::CMD_WRITE, 25'h1FFFFF0, 8'h00, 1'b0);
    // five tags in set 0: fills every way, evicts by lru, hits other ways
    for (int t = 1; t <= 5; t++)
      access(wpc_pkg::CMD_READ, {15'(t), 6'd0, 4'd3}, 8'h00, 1'b0);
    access(wpc_pkg::CMD_READ, {15'd2, 6'd0, 4'd7}, 8'h00, 1'b0);
    access(wpc_pkg::CMD_WRITE, {15'd4, 6'd0, 4'd0}, 8'hA5, 1'b0);

    while (items < 380) begin
      if (items > 150 && !hold_done) begin
        // long hold-off on the result side while reads keep coming
        hold_done = 1'b1;
        hold_req = 1'b1;
        burst_req = req_seen;
        for (int k = 0; k < 12; k++) begin
          send_word(wpc_pkg::CMD_READ, pool_addr(), 8'($urandom));
          runs_sent++;
        end
        wait_runs();
        if (req_seen != burst_req) begin
          for (int j = 0; j < 16; j++)
            send_word(wpc_pkg::CMD_FILL, 25'($urandom), 8'($urandom));
          runs_sent++;
          wait_runs();
        end
      end else begin
        case ($urandom_range(0, 19))
          0: send_word(CMD_NONE, 25'($urandom), 8'($urandom));
          1: send_word(wpc_pkg::CMD_FILL, 25'($urandom), 8'($urandom));
          2: access(2'($urandom_range(0, 1)), 25'($urandom), 8'($urandom), 1'b0);
          default: access(2'($urandom_range(0, 1)), pool_addr(), 8'($urandom), 1'b0);
        endcase
      end
    end

    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
